[rtl/srer_pkg.sv]
// Shared widths, item and configuration types, register indexes and helpers
// for the satellite range pipeline. No dependencies.
`timescale 1ns / 1ps

package srer_pkg;

   localparam int ROTATION_PASSES = 2;

   localparam int POS_W = 35;
   localparam int BIAS_W = 33;
   localparam int TSUM_W = 34;
   localparam int CORR_W = 32;
   localparam int OUT_W = 36;
   localparam int LIGHT_W = 29;
   localparam int RATE_W = 35;
   localparam int CSR_DATA_W = 35;
   localparam int CSR_INDEX_W = 2;

   localparam int AXES = 3;
   localparam int FRONT_STAGES = 7;
   localparam int ANGLE_W = 62;
   localparam int ANGLE_LO_W = 31;
   localparam int ROT_PROD_W = POS_W + ANGLE_LO_W;
   localparam int ROT_SUM_W = ROT_PROD_W + ANGLE_LO_W;
   localparam int ROUND_SHIFT = 56;
   localparam int ROT_W = ROT_SUM_W - ROUND_SHIFT;
   localparam int DIFF_W = 44;
   localparam int HALF_W = 21;
   localparam int MAG_W = 2 * HALF_W;
   localparam int PART_W = 2 * HALF_W;
   localparam int SUMSQ_W = 86;
   localparam int RANGE_W = 43;
   localparam int RANGE_LO_W = 22;
   localparam int RATE_PROD_W = RATE_W + RANGE_LO_W;
   localparam int NUM_W = 80;
   localparam int DIV_W = LIGHT_W + 1;
   localparam int CLK_PROD_W = 63;
   localparam int CLK_SHIFT = 32;
   localparam int CLK_W = 33;
   localparam int RHO_W = 46;

   localparam int RANGE_STAGES = FRONT_STAGES + RANGE_W;
   localparam int ANGLE_STAGES = 3 + ANGLE_W;
   localparam int FINAL_STAGES = 4;
   localparam int PIPE_LATENCY = (ROTATION_PASSES + 1) * RANGE_STAGES
                                 + ROTATION_PASSES * ANGLE_STAGES + FINAL_STAGES;

   localparam logic [LIGHT_W-1:0] LIGHT_RESET = 29'd299792458;
   localparam logic [RATE_W-1:0] RATE_RESET = 35'd20525479000;
   localparam logic [ANGLE_W-1:0] ANGLE_MAX = {ANGLE_W{1'b1}};
   localparam logic signed [RHO_W-1:0] OUT_MAX = (RHO_W'(1) << (OUT_W - 1)) - RHO_W'(1);
   localparam logic signed [RHO_W-1:0] OUT_MIN = -(RHO_W'(1) << (OUT_W - 1));

   localparam logic [CSR_INDEX_W-1:0] CSR_LIGHT_SPEED = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EARTH_RATE = 2'd1;

   typedef struct packed {
      logic signed [POS_W-1:0] sat_x;
      logic signed [POS_W-1:0] sat_y;
      logic signed [POS_W-1:0] sat_z;
      logic signed [POS_W-1:0] rx_x;
      logic signed [POS_W-1:0] rx_y;
      logic signed [POS_W-1:0] rx_z;
      logic signed [TSUM_W-1:0] tsum;
      logic signed [CORR_W-1:0] corr;
   } item_type;

   typedef struct packed {
      logic [LIGHT_W-1:0] light_speed;
      logic [RATE_W-1:0] earth_rate;
   } cfg_type;

   // A light speed of zero is used as one.
   function automatic logic [LIGHT_W-1:0] eff_light(input logic [LIGHT_W-1:0] c);
      return (c == '0) ? LIGHT_W'(1) : c;
   endfunction

endpackage

[rtl/srer_range.sv]
// One range pass: rotates the satellite position by the given angle and
// takes the slant range with a bit-per-stage square root. Uses srer_pkg.
`timescale 1ns / 1ps

module srer_range (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  srer_pkg::item_type in_item,
   input  logic [srer_pkg::ANGLE_W-1:0] in_angle,
   output logic out_valid,
   output srer_pkg::item_type out_item,
   output logic [srer_pkg::RANGE_W-1:0] out_range
);

   logic fr_valid_ff [srer_pkg::FRONT_STAGES];
   srer_pkg::item_type fr_item_ff [srer_pkg::FRONT_STAGES];

   logic [srer_pkg::POS_W-1:0] mag_x_in, mag_y_in;
   logic [srer_pkg::ANGLE_LO_W-1:0] ang_lo_in, ang_hi_in;
   logic [srer_pkg::ROT_PROD_W-1:0] r1_px_lo_ff, r1_px_hi_ff, r1_py_lo_ff, r1_py_hi_ff;
   logic [srer_pkg::ROT_SUM_W-1:0] sum_x_in, sum_y_in;
   logic [srer_pkg::ROT_W-1:0] r2_tx_ff, r2_ty_ff;
   logic signed [srer_pkg::DIFF_W-1:0] tx_s_in, ty_s_in;
   logic signed [srer_pkg::DIFF_W-1:0] r3_d_ff [srer_pkg::AXES];
   logic [srer_pkg::MAG_W-1:0] r4_mag_ff [srer_pkg::AXES];
   logic [srer_pkg::PART_W-1:0] r5_hh_ff [srer_pkg::AXES];
   logic [srer_pkg::PART_W-1:0] r5_hl_ff [srer_pkg::AXES];
   logic [srer_pkg::PART_W-1:0] r5_ll_ff [srer_pkg::AXES];
   logic [srer_pkg::SUMSQ_W-1:0] r6_sq_ff [srer_pkg::AXES];
   logic [srer_pkg::SUMSQ_W-1:0] r7_sum_ff;

   logic sq_valid_ff [srer_pkg::RANGE_W];
   srer_pkg::item_type sq_item_ff [srer_pkg::RANGE_W];
   logic [srer_pkg::SUMSQ_W-1:0] sq_rem_ff [srer_pkg::RANGE_W];
   logic [srer_pkg::RANGE_W-1:0] sq_root_ff [srer_pkg::RANGE_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < srer_pkg::FRONT_STAGES; s++) begin
            fr_valid_ff[s] <= 1'b0;
         end
      end else begin
         fr_valid_ff[0] <= in_valid;
         for (int s = 1; s < srer_pkg::FRONT_STAGES; s++) begin
            fr_valid_ff[s] <= fr_valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      fr_item_ff[0] <= in_item;
      for (int s = 1; s < srer_pkg::FRONT_STAGES; s++) begin
         fr_item_ff[s] <= fr_item_ff[s-1];
      end
   end

   assign mag_x_in = in_item.sat_x[srer_pkg::POS_W-1] ? srer_pkg::POS_W'(-in_item.sat_x)
                                                      : srer_pkg::POS_W'(in_item.sat_x);
   assign mag_y_in = in_item.sat_y[srer_pkg::POS_W-1] ? srer_pkg::POS_W'(-in_item.sat_y)
                                                      : srer_pkg::POS_W'(in_item.sat_y);
   assign ang_lo_in = in_angle[srer_pkg::ANGLE_LO_W-1:0];
   assign ang_hi_in = in_angle[srer_pkg::ANGLE_W-1:srer_pkg::ANGLE_LO_W];

   always_ff @(posedge clock) begin
      r1_px_lo_ff <= srer_pkg::ROT_PROD_W'(mag_x_in) * srer_pkg::ROT_PROD_W'(ang_lo_in);
      r1_px_hi_ff <= srer_pkg::ROT_PROD_W'(mag_x_in) * srer_pkg::ROT_PROD_W'(ang_hi_in);
      r1_py_lo_ff <= srer_pkg::ROT_PROD_W'(mag_y_in) * srer_pkg::ROT_PROD_W'(ang_lo_in);
      r1_py_hi_ff <= srer_pkg::ROT_PROD_W'(mag_y_in) * srer_pkg::ROT_PROD_W'(ang_hi_in);
   end

   // Rotation terms are rounded to nearest with ties away from zero.
   assign sum_x_in = (srer_pkg::ROT_SUM_W'(r1_px_hi_ff) << srer_pkg::ANGLE_LO_W)
                     + srer_pkg::ROT_SUM_W'(r1_px_lo_ff)
                     + (srer_pkg::ROT_SUM_W'(1) << (srer_pkg::ROUND_SHIFT - 1));
   assign sum_y_in = (srer_pkg::ROT_SUM_W'(r1_py_hi_ff) << srer_pkg::ANGLE_LO_W)
                     + srer_pkg::ROT_SUM_W'(r1_py_lo_ff)
                     + (srer_pkg::ROT_SUM_W'(1) << (srer_pkg::ROUND_SHIFT - 1));

   always_ff @(posedge clock) begin
      r2_tx_ff <= sum_x_in[srer_pkg::ROT_SUM_W-1:srer_pkg::ROUND_SHIFT];
      r2_ty_ff <= sum_y_in[srer_pkg::ROT_SUM_W-1:srer_pkg::ROUND_SHIFT];
   end

   assign tx_s_in = $signed(srer_pkg::DIFF_W'(r2_tx_ff));
   assign ty_s_in = $signed(srer_pkg::DIFF_W'(r2_ty_ff));

   always_ff @(posedge clock) begin
      r3_d_ff[0] <= srer_pkg::DIFF_W'(fr_item_ff[1].sat_x)
                    + (fr_item_ff[1].sat_y[srer_pkg::POS_W-1] ? -ty_s_in : ty_s_in)
                    - srer_pkg::DIFF_W'(fr_item_ff[1].rx_x);
      r3_d_ff[1] <= srer_pkg::DIFF_W'(fr_item_ff[1].sat_y)
                    + (fr_item_ff[1].sat_x[srer_pkg::POS_W-1] ? tx_s_in : -tx_s_in)
                    - srer_pkg::DIFF_W'(fr_item_ff[1].rx_y);
      r3_d_ff[2] <= srer_pkg::DIFF_W'(fr_item_ff[1].sat_z)
                    - srer_pkg::DIFF_W'(fr_item_ff[1].rx_z);
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < srer_pkg::AXES; a++) begin
         r4_mag_ff[a] <= r3_d_ff[a][srer_pkg::DIFF_W-1] ? srer_pkg::MAG_W'(-r3_d_ff[a])
                                                        : srer_pkg::MAG_W'(r3_d_ff[a]);
         r5_hh_ff[a] <= srer_pkg::PART_W'(r4_mag_ff[a][srer_pkg::MAG_W-1:srer_pkg::HALF_W])
                        * srer_pkg::PART_W'(r4_mag_ff[a][srer_pkg::MAG_W-1:srer_pkg::HALF_W]);
         r5_hl_ff[a] <= srer_pkg::PART_W'(r4_mag_ff[a][srer_pkg::MAG_W-1:srer_pkg::HALF_W])
                        * srer_pkg::PART_W'(r4_mag_ff[a][srer_pkg::HALF_W-1:0]);
         r5_ll_ff[a] <= srer_pkg::PART_W'(r4_mag_ff[a][srer_pkg::HALF_W-1:0])
                        * srer_pkg::PART_W'(r4_mag_ff[a][srer_pkg::HALF_W-1:0]);
         r6_sq_ff[a] <= (srer_pkg::SUMSQ_W'(r5_hh_ff[a]) << (2 * srer_pkg::HALF_W))
                        + (srer_pkg::SUMSQ_W'(r5_hl_ff[a]) << (srer_pkg::HALF_W + 1))
                        + srer_pkg::SUMSQ_W'(r5_ll_ff[a]);
      end
      r7_sum_ff <= r6_sq_ff[0] + r6_sq_ff[1] + r6_sq_ff[2];
   end

   for (genvar k = 0; k < srer_pkg::RANGE_W; k++) begin : g_sqrt
      localparam int BIT = srer_pkg::RANGE_W - 1 - k;
      logic prev_valid;
      srer_pkg::item_type prev_item;
      logic [srer_pkg::SUMSQ_W-1:0] prev_rem, trial;
      logic [srer_pkg::RANGE_W-1:0] prev_root;

      if (k == 0) begin : g_first
         assign prev_valid = fr_valid_ff[srer_pkg::FRONT_STAGES-1];
         assign prev_item = fr_item_ff[srer_pkg::FRONT_STAGES-1];
         assign prev_rem = r7_sum_ff;
         assign prev_root = '0;
      end else begin : g_next
         assign prev_valid = sq_valid_ff[k-1];
         assign prev_item = sq_item_ff[k-1];
         assign prev_rem = sq_rem_ff[k-1];
         assign prev_root = sq_root_ff[k-1];
      end

      assign trial = (srer_pkg::SUMSQ_W'(prev_root) << (BIT + 1))
                     + (srer_pkg::SUMSQ_W'(1) << (2 * BIT));

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else begin
            sq_valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         sq_item_ff[k] <= prev_item;
         if (prev_rem >= trial) begin
            sq_rem_ff[k] <= prev_rem - trial;
            sq_root_ff[k] <= prev_root | (srer_pkg::RANGE_W'(1) << BIT);
         end else begin
            sq_rem_ff[k] <= prev_rem;
            sq_root_ff[k] <= prev_root;
         end
      end
   end

   assign out_valid = sq_valid_ff[srer_pkg::RANGE_W-1];
   assign out_item = sq_item_ff[srer_pkg::RANGE_W-1];
   assign out_range = sq_root_ff[srer_pkg::RANGE_W-1];

endmodule

[rtl/srer_angle.sv]
// Rotation angle from a range: multiplies by the Earth rate and divides by
// twice the light speed one quotient bit per stage. Uses srer_pkg.
`timescale 1ns / 1ps

module srer_angle (
   input  logic clock,
   input  logic reset,
   input  srer_pkg::cfg_type cfg,
   input  logic in_valid,
   input  srer_pkg::item_type in_item,
   input  logic [srer_pkg::RANGE_W-1:0] in_range,
   output logic out_valid,
   output srer_pkg::item_type out_item,
   output logic [srer_pkg::ANGLE_W-1:0] out_angle
);

   logic [srer_pkg::LIGHT_W-1:0] light;
   logic [srer_pkg::DIV_W-1:0] divisor;

   logic m1_valid_ff, m2_valid_ff, d0_valid_ff;
   srer_pkg::item_type m1_item_ff, m2_item_ff, d0_item_ff;
   logic [srer_pkg::RATE_PROD_W-1:0] m1_lo_ff, m1_hi_ff;
   logic [srer_pkg::NUM_W-1:0] num_in, m2_num_ff;
   logic [srer_pkg::DIV_W-1:0] d0_rem_ff;
   logic [srer_pkg::ANGLE_W-1:0] d0_low_ff;
   logic d0_ovf_ff;

   logic dv_valid_ff [srer_pkg::ANGLE_W];
   srer_pkg::item_type dv_item_ff [srer_pkg::ANGLE_W];
   logic [srer_pkg::DIV_W-1:0] dv_rem_ff [srer_pkg::ANGLE_W];
   logic [srer_pkg::ANGLE_W-1:0] dv_low_ff [srer_pkg::ANGLE_W];
   logic [srer_pkg::ANGLE_W-1:0] dv_q_ff [srer_pkg::ANGLE_W];
   logic dv_ovf_ff [srer_pkg::ANGLE_W];

   assign light = srer_pkg::eff_light(cfg.light_speed);
   assign divisor = {light, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         d0_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= in_valid;
         m2_valid_ff <= m1_valid_ff;
         d0_valid_ff <= m2_valid_ff;
      end
   end

   // Numerator is 2*W*R + c, so the quotient rounds half up.
   assign num_in = (((srer_pkg::NUM_W'(m1_hi_ff) << srer_pkg::RANGE_LO_W)
                     + srer_pkg::NUM_W'(m1_lo_ff)) << 1) + srer_pkg::NUM_W'(light);

   always_ff @(posedge clock) begin
      m1_item_ff <= in_item;
      m1_lo_ff <= srer_pkg::RATE_PROD_W'(cfg.earth_rate)
                  * srer_pkg::RATE_PROD_W'(in_range[srer_pkg::RANGE_LO_W-1:0]);
      m1_hi_ff <= srer_pkg::RATE_PROD_W'(cfg.earth_rate)
                  * srer_pkg::RATE_PROD_W'(in_range[srer_pkg::RANGE_W-1:srer_pkg::RANGE_LO_W]);
      m2_item_ff <= m1_item_ff;
      m2_num_ff <= num_in;
      d0_item_ff <= m2_item_ff;
      d0_rem_ff <= srer_pkg::DIV_W'(m2_num_ff[srer_pkg::NUM_W-1:srer_pkg::ANGLE_W]);
      d0_low_ff <= m2_num_ff[srer_pkg::ANGLE_W-1:0];
      d0_ovf_ff <= srer_pkg::DIV_W'(m2_num_ff[srer_pkg::NUM_W-1:srer_pkg::ANGLE_W]) >= divisor;
   end

   for (genvar j = 0; j < srer_pkg::ANGLE_W; j++) begin : g_div
      localparam int BIT = srer_pkg::ANGLE_W - 1 - j;
      logic prev_valid, prev_ovf;
      srer_pkg::item_type prev_item;
      logic [srer_pkg::DIV_W-1:0] prev_rem;
      logic [srer_pkg::ANGLE_W-1:0] prev_low, prev_q;
      logic [srer_pkg::DIV_W:0] trial;

      if (j == 0) begin : g_first
         assign prev_valid = d0_valid_ff;
         assign prev_item = d0_item_ff;
         assign prev_rem = d0_rem_ff;
         assign prev_low = d0_low_ff;
         assign prev_q = '0;
         assign prev_ovf = d0_ovf_ff;
      end else begin : g_next
         assign prev_valid = dv_valid_ff[j-1];
         assign prev_item = dv_item_ff[j-1];
         assign prev_rem = dv_rem_ff[j-1];
         assign prev_low = dv_low_ff[j-1];
         assign prev_q = dv_q_ff[j-1];
         assign prev_ovf = dv_ovf_ff[j-1];
      end

      assign trial = {prev_rem, prev_low[BIT]};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j] <= 1'b0;
         end else begin
            dv_valid_ff[j] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         dv_item_ff[j] <= prev_item;
         dv_low_ff[j] <= prev_low;
         dv_ovf_ff[j] <= prev_ovf;
         if (trial >= {1'b0, divisor}) begin
            dv_rem_ff[j] <= srer_pkg::DIV_W'(trial - {1'b0, divisor});
            dv_q_ff[j] <= prev_q | (srer_pkg::ANGLE_W'(1) << BIT);
         end else begin
            dv_rem_ff[j] <= srer_pkg::DIV_W'(trial);
            dv_q_ff[j] <= prev_q;
         end
      end
   end

   assign out_valid = dv_valid_ff[srer_pkg::ANGLE_W-1];
   assign out_item = dv_item_ff[srer_pkg::ANGLE_W-1];
   assign out_angle = dv_ovf_ff[srer_pkg::ANGLE_W-1] ? srer_pkg::ANGLE_MAX
                                                     : dv_q_ff[srer_pkg::ANGLE_W-1];

endmodule

[rtl/satellite_range_earth_rotation_top.sv]
// Corrected satellite range with Earth rotation passes, fully pipelined.
// The pipeline has three range passes of 50 stages (square root, one bit
// per stage), two angle passes of 65 stages (divider, one bit per stage), 4 final.
// Throughput is one item per cycle; busy is high only while reset is held.
// Synchronous reset clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps

module satellite_range_earth_rotation_top (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [srer_pkg::POS_W-1:0] req_sat_x,
   input  logic signed [srer_pkg::POS_W-1:0] req_sat_y,
   input  logic signed [srer_pkg::POS_W-1:0] req_sat_z,
   input  logic signed [srer_pkg::POS_W-1:0] req_rx_x,
   input  logic signed [srer_pkg::POS_W-1:0] req_rx_y,
   input  logic signed [srer_pkg::POS_W-1:0] req_rx_z,
   input  logic signed [srer_pkg::BIAS_W-1:0] req_sat_clock_bias,
   input  logic signed [srer_pkg::BIAS_W-1:0] req_relativity_term,
   input  logic signed [srer_pkg::CORR_W-1:0] req_extra_correction,
   output logic rsp_valid,
   output logic signed [srer_pkg::OUT_W-1:0] rsp_corrected_range,
   input  logic csr_write_enable,
   input  logic [srer_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [srer_pkg::CSR_DATA_W-1:0] csr_write_data
);

   localparam int P = srer_pkg::ROTATION_PASSES;

   srer_pkg::cfg_type cfg_ff;
   srer_pkg::item_type req_item;
   logic [srer_pkg::LIGHT_W-1:0] light;

   logic rg_valid [P+1];
   srer_pkg::item_type rg_item [P+1];
   logic [srer_pkg::RANGE_W-1:0] rg_range [P+1];
   logic an_valid [P];
   srer_pkg::item_type an_item [P];
   logic [srer_pkg::ANGLE_W-1:0] an_angle [P];

   logic [srer_pkg::TSUM_W-1:0] tsum_mag_in;
   logic f1_valid_ff, f2_valid_ff, f3_valid_ff, rsp_valid_ff;
   logic [srer_pkg::CLK_PROD_W-1:0] f1_prod_ff;
   logic f1_neg_ff;
   logic [srer_pkg::RANGE_W-1:0] f1_range_ff, f2_range_ff;
   logic signed [srer_pkg::CORR_W-1:0] f1_corr_ff, f2_corr_ff;
   logic [srer_pkg::CLK_W-1:0] km_in;
   logic signed [srer_pkg::CLK_W-1:0] clk_in, f2_clk_ff;
   logic signed [srer_pkg::RHO_W-1:0] rho_in, f3_rho_ff, sat_in;
   logic signed [srer_pkg::OUT_W-1:0] rsp_range_ff;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_speed <= srer_pkg::LIGHT_RESET;
         cfg_ff.earth_rate <= srer_pkg::RATE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            srer_pkg::CSR_LIGHT_SPEED: begin
               cfg_ff.light_speed <= csr_write_data[srer_pkg::LIGHT_W-1:0];
            end
            srer_pkg::CSR_EARTH_RATE: begin
               cfg_ff.earth_rate <= csr_write_data[srer_pkg::RATE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign light = srer_pkg::eff_light(cfg_ff.light_speed);

   always_comb begin
      req_item.sat_x = req_sat_x;
      req_item.sat_y = req_sat_y;
      req_item.sat_z = req_sat_z;
      req_item.rx_x = req_rx_x;
      req_item.rx_y = req_rx_y;
      req_item.rx_z = req_rx_z;
      req_item.tsum = srer_pkg::TSUM_W'(req_sat_clock_bias)
                      + srer_pkg::TSUM_W'(req_relativity_term);
      req_item.corr = req_extra_correction;
   end

   srer_range u_range_first (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_item   (req_item),
      .in_angle  (srer_pkg::ANGLE_W'(0)),
      .out_valid (rg_valid[0]),
      .out_item  (rg_item[0]),
      .out_range (rg_range[0])
   );

   for (genvar p = 0; p < P; p++) begin : g_pass
      srer_angle u_angle (
         .clock     (clock),
         .reset     (reset),
         .cfg       (cfg_ff),
         .in_valid  (rg_valid[p]),
         .in_item   (rg_item[p]),
         .in_range  (rg_range[p]),
         .out_valid (an_valid[p]),
         .out_item  (an_item[p]),
         .out_angle (an_angle[p])
      );

      srer_range u_range (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (an_valid[p]),
         .in_item   (an_item[p]),
         .in_angle  (an_angle[p]),
         .out_valid (rg_valid[p+1]),
         .out_item  (rg_item[p+1]),
         .out_range (rg_range[p+1])
      );
   end

   assign tsum_mag_in = rg_item[P].tsum[srer_pkg::TSUM_W-1]
                        ? srer_pkg::TSUM_W'(-rg_item[P].tsum)
                        : srer_pkg::TSUM_W'(rg_item[P].tsum);

   assign km_in = srer_pkg::CLK_W'(f1_prod_ff[srer_pkg::CLK_PROD_W-1:srer_pkg::CLK_SHIFT])
                  + srer_pkg::CLK_W'(f1_prod_ff[srer_pkg::CLK_SHIFT-1]);
   assign clk_in = f1_neg_ff ? -$signed(km_in) : $signed(km_in);
   assign rho_in = $signed(srer_pkg::RHO_W'(f2_range_ff)) - srer_pkg::RHO_W'(f2_clk_ff)
                   - srer_pkg::RHO_W'(f2_corr_ff);
   assign sat_in = (f3_rho_ff > srer_pkg::OUT_MAX) ? srer_pkg::OUT_MAX
                 : (f3_rho_ff < srer_pkg::OUT_MIN) ? srer_pkg::OUT_MIN : f3_rho_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= rg_valid[P];
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         rsp_valid_ff <= f3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_prod_ff <= srer_pkg::CLK_PROD_W'(tsum_mag_in) * srer_pkg::CLK_PROD_W'(light);
      f1_neg_ff <= rg_item[P].tsum[srer_pkg::TSUM_W-1];
      f1_range_ff <= rg_range[P];
      f1_corr_ff <= rg_item[P].corr;
      f2_clk_ff <= clk_in;
      f2_range_ff <= f1_range_ff;
      f2_corr_ff <= f1_corr_ff;
      f3_rho_ff <= rho_in;
      rsp_range_ff <= srer_pkg::OUT_W'(sat_in);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_corrected_range = rsp_range_ff;

`ifndef NO_ASSERTIONS
   a_item_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(srer_pkg::PIPE_LATENCY) rsp_valid)
      else $error("An accepted item did not produce a result on time.");

   a_no_extra_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, srer_pkg::PIPE_LATENCY))
      else $error("A result appeared without a matching accepted item.");

   a_saturate_high: assert property (@(posedge clock) disable iff (reset)
      (f3_valid_ff && (f3_rho_ff > srer_pkg::OUT_MAX))
      |=> (rsp_corrected_range == srer_pkg::OUT_W'(srer_pkg::OUT_MAX)))
      else $error("An overflowing range was not clamped to the upper limit.");
`endif

endmodule

[bench/tb.sv]
// Self-checking testbench for satellite_range_earth_rotation_top: an item predictor,
// a bursty driver, a result monitor and register phases at several settings.
// Depends on rtl/srer_pkg.sv and rtl/satellite_range_earth_rotation_top.sv.
`timescale 1ns / 1ps

module tb;

   localparam logic [srer_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = srer_pkg::PIPE_LATENCY + 50;

   typedef struct {
      logic signed [srer_pkg::POS_W-1:0] sx, sy, sz, rx, ry, rz;
      logic signed [srer_pkg::BIAS_W-1:0] bias, rel;
      logic signed [srer_pkg::CORR_W-1:0] corr;
   } fix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [srer_pkg::POS_W-1:0] req_sat_x = '0, req_sat_y = '0, req_sat_z = '0;
   logic signed [srer_pkg::POS_W-1:0] req_rx_x = '0, req_rx_y = '0, req_rx_z = '0;
   logic signed [srer_pkg::BIAS_W-1:0] req_sat_clock_bias = '0, req_relativity_term = '0;
   logic signed [srer_pkg::CORR_W-1:0] req_extra_correction = '0;
   logic rsp_valid;
   logic signed [srer_pkg::OUT_W-1:0] rsp_corrected_range;
   logic csr_write_enable = 1'b0;
   logic [srer_pkg::CSR_INDEX_W-1:0] csr_index = srer_pkg::CSR_LIGHT_SPEED;
   logic [srer_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   fix_type pending_fixes[$];
   logic signed [srer_pkg::OUT_W-1:0] expected_ranges[$];
   fix_type on_port;
   logic [srer_pkg::LIGHT_W-1:0] light_reg = srer_pkg::LIGHT_RESET;
   logic [srer_pkg::RATE_W-1:0] rate_reg = srer_pkg::RATE_RESET;
   int burst_left = 5;
   int gap_left = 0;
   int errors = 0;
   int n_items = 0;
   int n_ranges = 0;
   int n_settings = 0;

   satellite_range_earth_rotation_top i_dut (.*);

   always #10 clock = ~clock;

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic longint unsigned slant_len(longint a[3], longint b[3]);
      logic [127:0] s, tt;
      longint unsigned d, r, t;
      s = '0;
      for (int i = 0; i < 3; i++) begin
         d = magnitude(a[i] - b[i]);
         s = s + 128'(d) * 128'(d);
      end
      r = 0;
      for (int k = 63; k >= 0; k--) begin
         t = r | (64'd1 << k);
         tt = 128'(t);
         if (tt * tt <= s) r = t;
      end
      return r;
   endfunction

   function automatic longint unsigned turn_angle(longint unsigned r, longint unsigned c);
      logic [127:0] num, q;
      num = 128'(rate_reg) * 128'(r) * 128'(2) + 128'(c);
      q = num / (128'(c) * 128'(2));
      return (q > 128'(srer_pkg::ANGLE_MAX)) ? 64'(srer_pkg::ANGLE_MAX) : q[63:0];
   endfunction

   function automatic longint rot_part(longint v, longint unsigned a);
      logic [127:0] p;
      p = 128'(magnitude(v)) * 128'(a) + (128'(1) << 55);
      p = p >> 56;
      return (v < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function automatic logic signed [srer_pkg::OUT_W-1:0] corrected_range_of(fix_type f);
      longint sat[3], rx[3], moved[3];
      longint tsum, clk, rho;
      longint unsigned c, rng, ang, km;
      c = (light_reg == '0) ? 64'd1 : 64'(light_reg);
      sat[0] = longint'(f.sx); sat[1] = longint'(f.sy); sat[2] = longint'(f.sz);
      rx[0] = longint'(f.rx); rx[1] = longint'(f.ry); rx[2] = longint'(f.rz);
      rng = slant_len(sat, rx);
      ang = turn_angle(rng, c);
      for (int p = 0; p < srer_pkg::ROTATION_PASSES; p++) begin
         moved[0] = sat[0] + rot_part(sat[1], ang);
         moved[1] = sat[1] - rot_part(sat[0], ang);
         moved[2] = sat[2];
         rng = slant_len(moved, rx);
         ang = turn_angle(rng, c);
      end
      tsum = longint'(f.bias) + longint'(f.rel);
      km = magnitude(tsum) * c;
      km = (km >> 32) + ((km >> 31) & 64'd1);
      clk = (tsum < 0) ? -longint'(km) : longint'(km);
      rho = longint'(rng) - clk - longint'(f.corr);
      if (rho > longint'(srer_pkg::OUT_MAX)) rho = longint'(srer_pkg::OUT_MAX);
      if (rho < longint'(srer_pkg::OUT_MIN)) rho = longint'(srer_pkg::OUT_MIN);
      return rho[srer_pkg::OUT_W-1:0];
   endfunction

   function automatic longint rnd_field(int w);
      longint v;
      v = longint'({$urandom, $urandom});
      v = (v <<< (64 - w)) >>> (64 - w);
      case ($urandom_range(0, 9))
         0: v = (longint'(1) <<< (w - 1)) - 1;
         1: v = -(longint'(1) <<< (w - 1));
         2, 3, 4, 5: v = v >>> $urandom_range(0, w - 1);
         default: ;
      endcase
      return v;
   endfunction

   function automatic fix_type random_fix();
      fix_type f;
      f.sx = srer_pkg::POS_W'(rnd_field(srer_pkg::POS_W));
      f.sy = srer_pkg::POS_W'(rnd_field(srer_pkg::POS_W));
      f.sz = srer_pkg::POS_W'(rnd_field(srer_pkg::POS_W));
      f.rx = srer_pkg::POS_W'(rnd_field(srer_pkg::POS_W));
      f.ry = srer_pkg::POS_W'(rnd_field(srer_pkg::POS_W));
      f.rz = srer_pkg::POS_W'(rnd_field(srer_pkg::POS_W));
      f.bias = srer_pkg::BIAS_W'(rnd_field(srer_pkg::BIAS_W));
      f.rel = srer_pkg::BIAS_W'(rnd_field(srer_pkg::BIAS_W));
      f.corr = srer_pkg::CORR_W'(rnd_field(srer_pkg::CORR_W));
      return f;
   endfunction

   function automatic fix_type make_fix(longint s, longint r, longint b, longint q,
                                        longint k);
      fix_type f;
      f.sx = srer_pkg::POS_W'(s); f.sy = srer_pkg::POS_W'(s); f.sz = srer_pkg::POS_W'(s);
      f.rx = srer_pkg::POS_W'(r); f.ry = srer_pkg::POS_W'(r); f.rz = srer_pkg::POS_W'(r);
      f.bias = srer_pkg::BIAS_W'(b); f.rel = srer_pkg::BIAS_W'(q);
      f.corr = srer_pkg::CORR_W'(k);
      return f;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            expected_ranges.push_back(corrected_range_of(on_port));
            n_items++;
         end
         if (gap_left > 0 || pending_fixes.size() == 0) begin
            if (gap_left > 0) gap_left--;
            start <= 1'b0;
         end else begin
            on_port = pending_fixes.pop_front();
            req_sat_x <= on_port.sx;
            req_sat_y <= on_port.sy;
            req_sat_z <= on_port.sz;
            req_rx_x <= on_port.rx;
            req_rx_y <= on_port.ry;
            req_rx_z <= on_port.rz;
            req_sat_clock_bias <= on_port.bias;
            req_relativity_term <= on_port.rel;
            req_extra_correction <= on_port.corr;
            start <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_ranges.size() == 0) begin
            $display("%0t unexpected result, expected none got %0d", $time,
                     rsp_corrected_range);
            errors++;
         end else begin
            if (rsp_corrected_range !== expected_ranges[0]) begin
               $display("%0t corrected_range mismatch, expected %0d got %0d", $time,
                        expected_ranges[0], rsp_corrected_range);
               errors++;
            end
            void'(expected_ranges.pop_front());
            n_ranges++;
         end
      end
   end

   task automatic wait_idle();
      while (pending_fixes.size() != 0 || start || expected_ranges.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(logic [srer_pkg::CSR_INDEX_W-1:0] idx,
                            logic [srer_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == srer_pkg::CSR_LIGHT_SPEED) light_reg = val[srer_pkg::LIGHT_W-1:0];
      else if (idx == srer_pkg::CSR_EARTH_RATE) rate_reg = val[srer_pkg::RATE_W-1:0];
   endtask

   task automatic run_setting(logic [srer_pkg::LIGHT_W-1:0] c,
                              logic [srer_pkg::RATE_W-1:0] w, int count);
      wait_idle();
      write_reg(srer_pkg::CSR_LIGHT_SPEED, srer_pkg::CSR_DATA_W'(c));
      write_reg(srer_pkg::CSR_EARTH_RATE, srer_pkg::CSR_DATA_W'(w));
      n_settings++;
      for (int i = 0; i < count; i++) pending_fixes.push_back(random_fix());
   endtask

   initial begin
      longint pmax, pmin, bmax, bmin, cmax, cmin, far_pos;
      pmax = (longint'(1) <<< (srer_pkg::POS_W - 1)) - 1;
      pmin = -(longint'(1) <<< (srer_pkg::POS_W - 1));
      bmax = (longint'(1) <<< (srer_pkg::BIAS_W - 1)) - 1;
      bmin = -(longint'(1) <<< (srer_pkg::BIAS_W - 1));
      cmax = (longint'(1) <<< (srer_pkg::CORR_W - 1)) - 1;
      cmin = -(longint'(1) <<< (srer_pkg::CORR_W - 1));
      far_pos = 64'sd5000000000;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      pending_fixes.push_back(make_fix(0, 0, 0, 0, 0));
      pending_fixes.push_back(make_fix(pmax, pmax, 0, 0, 0));
      pending_fixes.push_back(make_fix(pmax, pmin, 0, 0, 0));
      pending_fixes.push_back(make_fix(pmin, pmax, bmin, bmin, cmin));
      pending_fixes.push_back(make_fix(pmin, pmax, bmax, bmax, cmax));
      pending_fixes.push_back(make_fix(pmin, pmin, bmax, bmin, cmax));
      pending_fixes.push_back(make_fix(far_pos, 1000000000, bmax, bmax, cmax));
      pending_fixes.push_back(make_fix(-far_pos, 1000000000, bmin, bmax, cmin));
      pending_fixes.push_back(make_fix(-1, 0, -1, 0, -1));
      pending_fixes.push_back(make_fix(1, -1, 1, 1, 1));
      pending_fixes.push_back(make_fix(0, 0, bmax, bmax, cmin));
      pending_fixes.push_back(make_fix(0, 0, bmin, bmin, cmax));
      for (int i = 0; i < 300; i++) pending_fixes.push_back(random_fix());
      n_settings++;
      wait_idle();
      run_setting({srer_pkg::LIGHT_W{1'b1}}, {srer_pkg::RATE_W{1'b1}}, 150);
      pending_fixes.push_back(make_fix(pmax, pmin, bmax, bmax, cmin));
      run_setting('0, srer_pkg::RATE_RESET, 150);
      pending_fixes.push_back(make_fix(pmin, pmax, bmin, bmin, cmax));
      run_setting(srer_pkg::LIGHT_W'(1), {srer_pkg::RATE_W{1'b1}}, 150);
      pending_fixes.push_back(make_fix(pmax, pmin, 0, 0, 0));
      run_setting(srer_pkg::LIGHT_W'($urandom), '0, 150);
      wait_idle();
      write_reg(CSR_UNUSED, {srer_pkg::CSR_DATA_W{1'b1}});
      run_setting(srer_pkg::LIGHT_W'($urandom), srer_pkg::RATE_W'({$urandom, $urandom}),
                  100);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_ranges.size() != 0) errors++;
      $display("tb summary: %0d items over %0d register settings, %0d ranges checked",
               n_items, n_settings, n_ranges);
      $display("tb summary: %0d mismatches", errors);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: done, errors");
      $finish;
   end

endmodule

[filelist.f]
rtl/srer_pkg.sv
rtl/srer_range.sv
rtl/srer_angle.sv
rtl/satellite_range_earth_rotation_top.sv
bench/tb.sv
